// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by rse_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define RSE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// The expression must never be true outside reset.
`define RSE_ASSERT_NEVER(label, clk, rst_n, expr) \
	`RSE_ASSERT(label, clk, rst_n, !(expr))

`endif

// File: rtl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Types, constants and GF(256) arithmetic shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

	typedef struct packed {
		logic [7:0] message_symbol;
		logic       last_symbol;
	} rse_in_t;

	typedef struct packed {
		logic [7:0] code_symbol;
		logic       is_parity;
		logic       end_of_codeword;
	} rse_out_t;

	typedef struct packed {
		logic init_gen;
		logic build_step;
		logic align_shift;
		logic clear_rem;
		logic lfsr_step;
		logic drain_shift;
		logic load_msg;
		logic load_par;
		logic eoc;
	} rse_cmd_t;

	localparam logic       REG_PARITY_PAIRS = 1'b0;
	localparam logic       REG_FIELD_POLY   = 1'b1;

	localparam logic [4:0] PARITY_PAIRS_RESET = 5'd8;
	localparam logic [8:0] FIELD_POLY_RESET   = 9'h11D;

	localparam logic [7:0] ALPHA    = 8'h02;
	localparam logic [7:0] GEN_LEAD = 8'h01;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] low);
		logic [7:0] x;
		logic [7:0] acc;
		logic       carry;
		x   = a;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			carry = x[7];
			x     = {x[6:0], 1'b0};
			if (carry) begin
				x = x ^ low;
			end
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rse_cfg.sv
// ----------------------------------------------------------------------------
// rse_cfg
// APB register file holding the parity pair count and the field polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_cfg import rse_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output logic                               cfg_wr,
	output logic [$clog2(MAX_PARITY+1)-1:0]    npar,
	output logic [7:0]                         gf_low
);

	localparam int NW = $clog2(MAX_PARITY + 1);

	logic [4:0] pairs_q;
	logic [8:0] poly_q;
	logic [6:0] twice_t;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= PARITY_PAIRS_RESET;
			poly_q  <= FIELD_POLY_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PARITY_PAIRS: pairs_q <= pwdata[4:0];
				REG_FIELD_POLY:   poly_q  <= pwdata[8:0];
				default:          pairs_q <= pairs_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PARITY_PAIRS: prdata = {27'd0, pairs_q};
			REG_FIELD_POLY:   prdata = {23'd0, poly_q};
			default:          prdata = '0;
		endcase
	end

	assign twice_t = {1'b0, pairs_q, 1'b0};
	assign npar    = (twice_t > 7'(MAX_PARITY)) ? NW'(MAX_PARITY) : NW'(twice_t);
	assign gf_low  = poly_q[7:0];

endmodule

`default_nettype wire

// File: rtl/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl
// Sequencer for generator build, message pass-through and parity drain.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_ctrl import rse_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr,
	input  logic [$clog2(MAX_PARITY+1)-1:0] npar,
	input  logic                            symbol_valid,
	input  logic                            last_symbol,
	output logic                            symbol_stall,
	output logic                            code_valid,
	input  logic                            code_stall,
	output rse_cmd_t                        cmd
);

	localparam int NW   = $clog2(MAX_PARITY + 1);
	localparam int CNTW = $clog2(MAX_PARITY);

	typedef enum logic [1:0] {ST_INIT, ST_BUILD, ST_RUN, ST_DRAIN} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_q;
	logic            out_valid_q;
	logic [NW-1:0]   cnt_ext;
	logic            out_free;
	logic            accept;

	assign cnt_ext      = NW'(cnt_q);
	assign out_free     = !out_valid_q || !code_stall;
	assign symbol_stall = !((state_q == ST_RUN) && out_free);
	assign accept       = symbol_valid && !symbol_stall;
	assign code_valid   = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_gen  = 1'b1;
				cmd.clear_rem = 1'b1;
			end
			ST_BUILD: begin
				if (cnt_ext < npar) begin
					cmd.build_step = 1'b1;
				end else begin
					cmd.align_shift = 1'b1;
				end
			end
			ST_RUN: begin
				if (accept) begin
					cmd.lfsr_step = 1'b1;
					cmd.load_msg  = 1'b1;
					cmd.eoc       = last_symbol && (npar == '0);
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					cmd.load_par    = 1'b1;
					cmd.drain_shift = 1'b1;
					cmd.eoc         = (cnt_ext + NW'(1)) == npar;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_msg || cmd.load_par) begin
				out_valid_q <= 1'b1;
			end else if (!code_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				state_q <= ST_INIT;
				cnt_q   <= '0;
			end else begin
				unique case (state_q)
					ST_INIT: begin
						state_q <= ST_BUILD;
						cnt_q   <= '0;
					end
					ST_BUILD: begin
						if (cnt_q == CNTW'(MAX_PARITY - 1)) begin
							state_q <= ST_RUN;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + CNTW'(1);
						end
					end
					ST_RUN: begin
						if (accept && last_symbol && (npar != '0)) begin
							state_q <= ST_DRAIN;
							cnt_q   <= '0;
						end
					end
					ST_DRAIN: begin
						if (out_free) begin
							if (cmd.eoc) begin
								state_q <= ST_RUN;
								cnt_q   <= '0;
							end else begin
								cnt_q <= cnt_q + CNTW'(1);
							end
						end
					end
					default: state_q <= ST_INIT;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rse_dp.sv
// ----------------------------------------------------------------------------
// rse_dp
// Generator register, remainder register, shared GF multiplier bank and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_dp import rse_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic       clk,
	input  rse_cmd_t   cmd,
	input  logic [7:0] gf_low,
	input  logic [7:0] message_symbol,
	output rse_out_t   code
);

	// Both registers are kept aligned to the top stage, so the feedback tap
	// and the parity output always sit at the highest index.
	logic [7:0] gen_q      [MAX_PARITY];
	logic [7:0] rem_q      [MAX_PARITY];
	logic [7:0] gen_below  [MAX_PARITY];
	logic [7:0] rem_below  [MAX_PARITY];
	logic [7:0] prod       [MAX_PARITY];
	logic [7:0] root_q;
	logic [7:0] fb;
	logic [7:0] mul_a;
	rse_out_t   code_q;

	assign fb    = message_symbol ^ rem_q[MAX_PARITY-1];
	assign mul_a = cmd.build_step ? root_q : fb;

	for (genvar k = 0; k < MAX_PARITY; k++) begin : g_tap
		if (k == 0) begin : g_bottom
			assign gen_below[k] = '0;
			assign rem_below[k] = '0;
		end else begin : g_upper
			assign gen_below[k] = gen_q[k-1];
			assign rem_below[k] = rem_q[k-1];
		end
		assign prod[k] = gf_mul(mul_a, gen_q[k], gf_low);
	end

	always_ff @(posedge clk) begin
		if (cmd.init_gen) begin
			root_q <= ALPHA;
			for (int k = 0; k < MAX_PARITY; k++) begin
				gen_q[k] <= (k == 0) ? GEN_LEAD : '0;
			end
		end else if (cmd.build_step) begin
			root_q <= gf_mul(root_q, ALPHA, gf_low);
			for (int k = 0; k < MAX_PARITY; k++) begin
				gen_q[k] <= gen_below[k] ^ prod[k];
			end
		end else if (cmd.align_shift) begin
			for (int k = 0; k < MAX_PARITY; k++) begin
				gen_q[k] <= gen_below[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_rem) begin
			for (int k = 0; k < MAX_PARITY; k++) begin
				rem_q[k] <= '0;
			end
		end else if (cmd.lfsr_step) begin
			for (int k = 0; k < MAX_PARITY; k++) begin
				rem_q[k] <= rem_below[k] ^ prod[k];
			end
		end else if (cmd.drain_shift) begin
			for (int k = 0; k < MAX_PARITY; k++) begin
				rem_q[k] <= rem_below[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_msg) begin
			code_q.code_symbol     <= message_symbol;
			code_q.is_parity       <= 1'b0;
			code_q.end_of_codeword <= cmd.eoc;
		end else if (cmd.load_par) begin
			code_q.code_symbol     <= rem_q[MAX_PARITY-1];
			code_q.is_parity       <= 1'b1;
			code_q.end_of_codeword <= cmd.eoc;
		end
	end

	assign code = code_q;

endmodule

`default_nettype wire

// File: rtl/reed_solomon_encoder.sv
// A message symbol appears on code in the cycle after it is accepted.
// Throughput: one message symbol per cycle while code is not stalled; a codeword's
// last symbol is followed by min(2t, MAX_PARITY) parity symbols at the same rate,
// during which no symbol is accepted. After reset or any register write the
// generator polynomial is rebuilt (one multiply step per root, then alignment).
// Reset is asynchronous; registers return to t = 8 and polynomial 0x11D.
// ----------------------------------------------------------------------------
// reed_solomon_encoder
// Systematic Reed-Solomon encoder over GF(256) with configurable parity.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_encoder import rse_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        symbol_valid,
	output logic        symbol_stall,
	input  rse_in_t     symbol,
	output logic        code_valid,
	input  logic        code_stall,
	output rse_out_t    code
);

	localparam int NW = $clog2(MAX_PARITY + 1);

	logic          cfg_wr;
	logic [NW-1:0] npar;
	logic [7:0]    gf_low;
	rse_cmd_t      cmd;

	rse_cfg #(.MAX_PARITY(MAX_PARITY)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg_wr  (cfg_wr),
		.npar    (npar),
		.gf_low  (gf_low)
	);

	rse_ctrl #(.MAX_PARITY(MAX_PARITY)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.npar         (npar),
		.symbol_valid (symbol_valid),
		.last_symbol  (symbol.last_symbol),
		.symbol_stall (symbol_stall),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.cmd          (cmd)
	);

	rse_dp #(.MAX_PARITY(MAX_PARITY)) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.gf_low         (gf_low),
		.message_symbol (symbol.message_symbol),
		.code           (code)
	);

endmodule

`default_nettype wire

// File: rtl/rse_checker.sv
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rse_checker import rse_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        pready,
	input logic        symbol_valid,
	input logic        symbol_stall,
	input logic        code_valid,
	input logic        code_stall,
	input rse_out_t    code
);

	logic code_held;
	logic parity_open;
	logic reg_write;

	assign code_held   = code_valid && code_stall;
	assign parity_open = code_valid && code.is_parity && !code.end_of_codeword;
	assign reg_write   = psel && penable && pwrite && pready;

	`RSE_ASSERT(a_code_hold, clk, arst_n, code_held |=> code_valid && $stable(code))

	`RSE_ASSERT_NEVER(a_pready_high, clk, arst_n, !pready)

	`RSE_ASSERT(a_drain_blocks_input, clk, arst_n, parity_open |-> symbol_stall)

	`RSE_ASSERT(a_write_rebuilds, clk, arst_n, reg_write |=> symbol_stall)

endmodule

bind reed_solomon_encoder rse_checker u_rse_checker (.*);

`default_nettype wire

// File: bench/rse_code_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rse_code_checker
// Watches the register port and both symbol channels of the Reed-Solomon
// encoder. It keeps its own copy of the configuration, the generator and the
// remainder, predicts every code symbol of each accepted request, and compares
// each accepted code symbol field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rse_code_checker import rse_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        symbol_valid,
	input  logic        symbol_stall,
	input  rse_in_t     symbol,
	input  logic        code_valid,
	input  logic        code_stall,
	input  rse_out_t    code,
	output int          mismatches,
	output int          outstanding
);

	logic [4:0] pairs_cfg;
	logic [8:0] poly_cfg;
	logic [7:0] gen_coef [MAX_PARITY];
	logic [7:0] remainder [MAX_PARITY];
	bit         gen_built;
	rse_out_t   expected_codes [$];

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b,
		input logic [8:0] poly);
		logic [7:0] x;
		logic [7:0] acc;
		x   = a;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ poly[7:0]) : {x[6:0], 1'b0};
		end
		return acc;
	endfunction

	function automatic int parity_len();
		int n;
		n = 2 * int'(pairs_cfg);
		return (n > MAX_PARITY) ? MAX_PARITY : n;
	endfunction

	function automatic void clear_remainder();
		foreach (remainder[k]) begin
			remainder[k] = '0;
		end
	endfunction

	// Generator is the product of (x + alpha^i) for i = 1..n; x^n is implicit.
	function automatic void build_generator(input int n);
		logic [7:0] coef [MAX_PARITY + 1];
		logic [7:0] root;
		foreach (coef[k]) begin
			coef[k] = '0;
		end
		coef[0] = GEN_LEAD;
		root    = GEN_LEAD;
		for (int i = 1; i <= n; i++) begin
			root = gf_times(root, ALPHA, poly_cfg);
			for (int k = i; k >= 1; k--) begin
				coef[k] = coef[k - 1] ^ gf_times(root, coef[k], poly_cfg);
			end
			coef[0] = gf_times(root, coef[0], poly_cfg);
		end
		for (int k = 0; k < MAX_PARITY; k++) begin
			gen_coef[k] = (k < n) ? coef[k] : '0;
		end
		gen_built = 1'b1;
	endfunction

	function automatic void apply_write(input logic [2:0] addr, input logic [31:0] data);
		if (addr[2] == REG_PARITY_PAIRS) begin
			pairs_cfg = data[4:0];
		end else begin
			poly_cfg = data[8:0];
		end
		gen_built = 1'b0;
		clear_remainder();
	endfunction

	function automatic void predict_codeword(input rse_in_t req);
		int         n;
		logic [7:0] fb;
		rse_out_t   c;
		n = parity_len();
		if (!gen_built) begin
			build_generator(n);
		end
		if (n > 0) begin
			fb = req.message_symbol ^ remainder[n - 1];
			for (int k = n - 1; k >= 1; k--) begin
				remainder[k] = remainder[k - 1] ^ gf_times(fb, gen_coef[k], poly_cfg);
			end
			remainder[0] = gf_times(fb, gen_coef[0], poly_cfg);
		end
		c.code_symbol     = req.message_symbol;
		c.is_parity       = 1'b0;
		c.end_of_codeword = req.last_symbol && (n == 0);
		expected_codes.push_back(c);
		if (req.last_symbol) begin
			for (int d = 0; d < n; d++) begin
				c.code_symbol     = remainder[n - 1 - d];
				c.is_parity       = 1'b1;
				c.end_of_codeword = (d == n - 1);
				expected_codes.push_back(c);
			end
			clear_remainder();
		end
	endfunction

	function automatic void compare_code(input rse_out_t got);
		rse_out_t want;
		if (expected_codes.size() == 0) begin
			$display("%0t: code symbol with none expected: expected none, actual %h",
				$time, got);
			mismatches++;
			return;
		end
		want = expected_codes.pop_front();
		if (got.code_symbol !== want.code_symbol) begin
			$display("%0t: code_symbol: expected %h, actual %h",
				$time, want.code_symbol, got.code_symbol);
			mismatches++;
		end
		if (got.is_parity !== want.is_parity) begin
			$display("%0t: is_parity: expected %b, actual %b",
				$time, want.is_parity, got.is_parity);
			mismatches++;
		end
		if (got.end_of_codeword !== want.end_of_codeword) begin
			$display("%0t: end_of_codeword: expected %b, actual %b",
				$time, want.end_of_codeword, got.end_of_codeword);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_cfg  = PARITY_PAIRS_RESET;
			poly_cfg   = FIELD_POLY_RESET;
			gen_built  = 1'b0;
			clear_remainder();
			expected_codes.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				apply_write(paddr, pwdata);
			end
			if (symbol_valid && !symbol_stall) begin
				predict_codeword(symbol);
			end
			if (code_valid && !code_stall) begin
				compare_code(code);
			end
		end
		outstanding = expected_codes.size();
	end

endmodule

// File: bench/tb_reed_solomon_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reed_solomon_encoder
// Drives message symbols and register writes into the Reed-Solomon encoder:
// a directed part over the field extremes and the special settings, then
// random codewords under several idling and stalling phases. A checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_reed_solomon_encoder;
	import rse_pkg::*;

	localparam int MAX_PARITY    = 32;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	localparam int PHASE_ITEMS   = 42;

	localparam logic [2:0] ADDR_PARITY_PAIRS = {REG_PARITY_PAIRS, 2'b00};
	localparam logic [2:0] ADDR_FIELD_POLY   = {REG_FIELD_POLY, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        symbol_valid;
	logic        symbol_stall;
	rse_in_t     symbol;
	logic        code_valid;
	logic        code_stall;
	rse_out_t    code;

	int mismatches;
	int outstanding;
	int idle_pct;
	int stall_pct;
	bit hold_toggle;
	int quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	reed_solomon_encoder #(
		.MAX_PARITY(MAX_PARITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.symbol_valid(symbol_valid),
		.symbol_stall(symbol_stall),
		.symbol(symbol),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code)
	);

	rse_code_checker #(
		.MAX_PARITY(MAX_PARITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.symbol_valid(symbol_valid),
		.symbol_stall(symbol_stall),
		.symbol(symbol),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// A long hold-off is requested by flipping hold_toggle.
	initial begin
		int hold_left;
		bit toggle_seen;
		hold_left   = 0;
		toggle_seen = 1'b0;
		code_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != toggle_seen) begin
				toggle_seen = hold_toggle;
				hold_left   = HOLD_CYCLES;
			end
			@(negedge clk);
			if (hold_left > 0) begin
				code_stall <= 1'b1;
				hold_left--;
			end else begin
				code_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((symbol_valid && !symbol_stall) || (code_valid && !code_stall) ||
			(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(negedge clk);
		end
		$display("end of test: mismatches");
		$finish;
	end

	task automatic offer_symbol(input logic [7:0] value, input logic last);
		rse_in_t req;
		req.message_symbol = value;
		req.last_symbol    = last;
		while ($urandom_range(99) < idle_pct) begin
			symbol_valid <= 1'b0;
			@(negedge clk);
		end
		symbol       <= req;
		symbol_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (symbol_stall);
		@(negedge clk);
	endtask

	task automatic send_message(input int len, input bit close);
		for (int i = 0; i < len; i++) begin
			offer_symbol(8'($urandom_range(255)), close && (i == len - 1));
		end
	endtask

	task automatic wait_for_codes();
		symbol_valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input int value, input int width);
		logic [31:0] mask;
		mask    = (32'd1 << width) - 32'd1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= ($urandom() & ~mask) | (value & mask);
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int pairs, input int poly);
		wait_for_codes();
		write_register(ADDR_PARITY_PAIRS, pairs, 5);
		write_register(ADDR_FIELD_POLY, poly, 9);
	endtask

	initial begin
		int len;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		symbol_valid = 1'b0;
		symbol       = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_toggle  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer_symbol(8'h00, 1'b0);
		offer_symbol(8'hFF, 1'b0);
		offer_symbol(8'h5A, 1'b1);
		offer_symbol(8'hA5, 1'b1);
		configure(0, FIELD_POLY_RESET);
		offer_symbol(8'h81, 1'b0);
		offer_symbol(8'h7E, 1'b1);
		configure(16, FIELD_POLY_RESET);
		offer_symbol(8'h01, 1'b0);
		offer_symbol(8'hFE, 1'b0);
		offer_symbol(8'h80, 1'b1);
		configure(31, FIELD_POLY_RESET);
		offer_symbol(8'h3C, 1'b1);
		configure(2, 9'h01D);
		offer_symbol(8'hC3, 1'b0);
		offer_symbol(8'hFF, 1'b1);
		configure(3, 9'h100);
		offer_symbol(8'h12, 1'b1);
		configure(1, 9'h1FF);
		offer_symbol(8'h40, 1'b0);
		offer_symbol(8'h02, 1'b0);
		configure(4, 9'h0FF);
		offer_symbol(8'h99, 1'b0);
		offer_symbol(8'h66, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 88;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 88;
				end
				default: begin
					idle_pct  = 25;
					stall_pct = 25;
				end
			endcase
			configure(($urandom_range(9) < 8) ? $urandom_range(9) : $urandom_range(31, 10),
				$urandom_range(1) ? FIELD_POLY_RESET : $urandom_range(511));
			if (ph == 0) begin
				hold_toggle = ~hold_toggle;
				send_message(48, 1'b1);
			end
			len = 0;
			while (len < PHASE_ITEMS) begin
				int n;
				n = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
				send_message(n, $urandom_range(9) != 0);
				len += n;
				if ($urandom_range(5) == 0) begin
					configure(($urandom_range(9) < 8) ? $urandom_range(9)
						: $urandom_range(31, 10),
						$urandom_range(1) ? FIELD_POLY_RESET : $urandom_range(511));
				end else if ($urandom_range(7) == 0) begin
					wait_for_codes();
				end
			end
		end

		wait_for_codes();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
